>>> hdl/frc_pkg.sv
// ----------------------------------------------------------------------------
// Frequency-ranked candidate table package
// Sizes, cell data and cell command types shared by the cell row and the top.
// ----------------------------------------------------------------------------
package frc_pkg;

    localparam int CAND_SLOTS   = 8;
    localparam int HOLDER_SLOTS = 8;

    localparam int ID_W    = 32;
    localparam int HITS_W  = 8;
    localparam int CIDX_W  = (CAND_SLOTS > 1) ? $clog2(CAND_SLOTS) : 1;
    localparam int PIDX_W  = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
    localparam int CNT_W   = $clog2(CAND_SLOTS + 1);
    localparam int PCNT_W  = $clog2(HOLDER_SLOTS + 1);
    localparam int SUM_W   = CNT_W + PCNT_W;

    localparam logic [HITS_W-1:0] HIT_LIMIT_RESET = 8'd16;

    typedef struct packed {
        logic [ID_W-1:0]   ident;
        logic [HITS_W-1:0] hits;
    } cell_data_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INC,
        CMD_DEC,
        CMD_FROM_UP,
        CMD_FROM_DOWN,
        CMD_LOAD
    } cell_cmd_t;

endpackage

>>> hdl/frc_cell.sv
// ----------------------------------------------------------------------------
// Candidate cell
// Holds one slot of the table and trades contents with its neighbors.
// ----------------------------------------------------------------------------
module frc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  frc_pkg::cell_cmd_t cmd,
    input  frc_pkg::cell_data_t up,
    input  frc_pkg::cell_data_t down,
    input  logic [31:0]        load_ident,
    output frc_pkg::cell_data_t q
);
    import frc_pkg::*;

    logic [ID_W-1:0]   ident_reg, ident_next;
    logic [HITS_W-1:0] hits_reg, hits_next;

    always_comb
    begin
        ident_next = ident_reg;
        hits_next  = hits_reg;
        unique case (cmd)
            CMD_HOLD:      ;
            CMD_INC:       hits_next = hits_reg + 8'd1;
            CMD_DEC:       hits_next = hits_reg - 8'd1;
            CMD_FROM_UP:
            begin
                ident_next = up.ident;
                hits_next  = up.hits;
            end
            CMD_FROM_DOWN:
            begin
                ident_next = down.ident;
                hits_next  = down.hits;
            end
            CMD_LOAD:
            begin
                ident_next = load_ident;
                hits_next  = 8'd1;
            end
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg <= '0;
        end
        else
        begin
            hits_reg <= hits_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ident_reg <= ident_next;
    end

    assign q.ident = ident_reg;
    assign q.hits  = hits_reg;

endmodule

>>> hdl/frequency_ranked_candidate_table.sv
// ----------------------------------------------------------------------------
// Frequency-ranked candidate table
// Hit-count sorted candidate list with buffered new ids and aging.
// ----------------------------------------------------------------------------
// An item is taken in idle; a hit that raises a count then bubbles the id up
// past slots with fewer hits. The item at the end of a list runs aging and,
// with buffered ids, a decide step and, where it chooses, a refill of slots,
// then reports the slots. New items stall until the table is idle again. Each
// report waits while the output stalls and leaves through one output register.
// Reset empties the table and buffer and sets the hit limit to 16.
module frequency_ranked_candidate_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] holder_id,
    input  logic [31:0] owner_id,
    input  logic        holder_valid,
    input  logic        end_of_list,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] slot_id,
    output logic [7:0]  slot_count,
    output logic        slot_valid,
    output logic [3:0]  candidate_total,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import frc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_BUBBLE = 6'b000010,
        ST_AGE    = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_REPORT = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [HITS_W-1:0] limit_reg;
    logic [CNT_W-1:0]  in_use_reg, in_use_next;
    logic [PCNT_W-1:0] pend_total_reg, pend_total_next;
    logic [PCNT_W-1:0] pend_k_reg, pend_k_next;
    logic [ID_W-1:0]   pend_mem [HOLDER_SLOTS];
    logic              eol_reg, eol_next;
    logic [CIDX_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  fill_j_reg, fill_j_next;
    logic [PCNT_W-1:0] fill_i_reg, fill_i_next;
    logic [CNT_W-1:0]  rep_reg, rep_next;

    logic              out_valid_reg;
    logic [ID_W-1:0]   slot_id_reg;
    logic [HITS_W-1:0] slot_count_reg;
    logic              slot_valid_reg;
    logic [3:0]        total_reg;
    logic              last_reg;
    logic              out_load;

    cell_cmd_t         cmd [CAND_SLOTS];
    cell_data_t        cq  [CAND_SLOTS];
    cell_data_t        cup [CAND_SLOTS];
    cell_data_t        cdn [CAND_SLOTS];

    logic              accept;
    logic              pend_write;
    logic              match;
    logic [CIDX_W-1:0] match_idx;
    logic [HITS_W-1:0] last_hits;
    logic              alive;
    logic [CNT_W-1:0]  dec_j;
    logic [SUM_W-1:0]  jk_sum;
    logic [CIDX_W-1:0] rep_idx;

    genvar g;
    generate
        for (g = 0; g < CAND_SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_top
                assign cup[g] = cq[g];
            end
            else
            begin : g_mid
                assign cup[g] = cq[g-1];
            end
            if (g == CAND_SLOTS - 1)
            begin : g_end
                assign cdn[g] = cq[g];
            end
            else
            begin : g_nxt
                assign cdn[g] = cq[g+1];
            end
            frc_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd[g]),
                .up         (cup[g]),
                .down       (cdn[g]),
                .load_ident (pend_mem[fill_i_reg[PIDX_W-1:0]]),
                .q          (cq[g])
            );
        end
    endgenerate

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_load  = !out_valid_reg || !out_stall;
    assign last_hits = cq[CIDX_W'(in_use_reg - CNT_W'(1))].hits;
    assign rep_idx   = rep_reg[CIDX_W-1:0];

    always_comb
    begin
        match     = 1'b0;
        match_idx = '0;
        for (int s = CAND_SLOTS - 1; s >= 0; s--)
        begin
            if ((CNT_W'(s) < in_use_reg) && (cq[s].ident == holder_id))
            begin
                match     = 1'b1;
                match_idx = CIDX_W'(s);
            end
        end
    end

    always_comb
    begin
        dec_j = '0;
        for (int i = 0; i < CAND_SLOTS; i++)
        begin
            if ((CNT_W'(i) < in_use_reg)
                && (cq[i].hits > ((last_hits != '0) ? 8'd1 : 8'd0)))
            begin
                dec_j = CNT_W'(i + 1);
            end
        end
    end

    assign jk_sum = SUM_W'(dec_j) + SUM_W'(pend_k_reg);

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        pend_total_next = pend_total_reg;
        pend_k_next     = pend_k_reg;
        eol_next        = eol_reg;
        ptr_next        = ptr_reg;
        fill_j_next     = fill_j_reg;
        fill_i_next     = fill_i_reg;
        rep_next        = rep_reg;
        pend_write      = 1'b0;
        alive           = 1'b1;
        for (int i = 0; i < CAND_SLOTS; i++)
        begin
            cmd[i] = CMD_HOLD;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eol_next   = end_of_list;
                    state_next = end_of_list ? ST_AGE : ST_IDLE;
                    if (holder_valid && (holder_id != owner_id))
                    begin
                        if (match)
                        begin
                            if (cq[match_idx].hits < limit_reg)
                            begin
                                cmd[match_idx] = CMD_INC;
                                ptr_next       = match_idx;
                                state_next     = ST_BUBBLE;
                            end
                        end
                        else if (pend_total_reg < PCNT_W'(HOLDER_SLOTS))
                        begin
                            pend_write      = 1'b1;
                            pend_total_next = pend_total_reg + PCNT_W'(1);
                        end
                    end
                end
            end
            ST_BUBBLE:
            begin
                if ((ptr_reg != '0) && (cq[ptr_reg].hits > cq[ptr_reg - CIDX_W'(1)].hits))
                begin
                    cmd[ptr_reg]               = CMD_FROM_UP;
                    cmd[ptr_reg - CIDX_W'(1)]  = CMD_FROM_DOWN;
                    ptr_next                   = ptr_reg - CIDX_W'(1);
                end
                else
                begin
                    state_next = eol_reg ? ST_AGE : ST_IDLE;
                end
            end
            ST_AGE:
            begin
                if (cq[0].hits == limit_reg)
                begin
                    for (int i = 0; i < CAND_SLOTS; i++)
                    begin
                        if (alive && (CNT_W'(i) < in_use_reg) && (cq[i].hits != '0))
                        begin
                            cmd[i] = CMD_DEC;
                        end
                        else
                        begin
                            alive = 1'b0;
                        end
                    end
                end
                pend_k_next     = pend_total_reg;
                pend_total_next = '0;
                rep_next        = '0;
                state_next      = (pend_total_reg != '0) ? ST_DECIDE : ST_REPORT;
            end
            ST_DECIDE:
            begin
                fill_i_next = '0;
                if ((in_use_reg == '0)
                    || ((last_hits != '0) && (in_use_reg < CNT_W'(CAND_SLOTS))))
                begin
                    fill_j_next = in_use_reg;
                    if ((SUM_W'(in_use_reg) + SUM_W'(pend_k_reg)) < SUM_W'(CAND_SLOTS))
                    begin
                        in_use_next = CNT_W'(in_use_reg + CNT_W'(pend_k_reg));
                    end
                    else
                    begin
                        in_use_next = CNT_W'(CAND_SLOTS);
                    end
                    state_next = ST_FILL;
                end
                else
                begin
                    if (last_hits != '0)
                    begin
                        for (int i = 0; i < CAND_SLOTS; i++)
                        begin
                            if ((CNT_W'(i) < in_use_reg) && (cq[i].hits != '0))
                            begin
                                cmd[i] = CMD_DEC;
                            end
                        end
                    end
                    if (last_hits > 8'd1)
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        fill_j_next = dec_j;
                        if (jk_sum > SUM_W'(in_use_reg))
                        begin
                            in_use_next = (jk_sum < SUM_W'(CAND_SLOTS))
                                        ? CNT_W'(jk_sum) : CNT_W'(CAND_SLOTS);
                        end
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                if ((fill_i_reg < pend_k_reg) && (fill_j_reg < in_use_reg))
                begin
                    cmd[fill_j_reg[CIDX_W-1:0]] = CMD_LOAD;
                    fill_i_next = fill_i_reg + PCNT_W'(1);
                    fill_j_next = fill_j_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_load)
                begin
                    rep_next = rep_reg + CNT_W'(1);
                    if ((in_use_reg == '0) || ((rep_reg + CNT_W'(1)) == in_use_reg))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            limit_reg      <= HIT_LIMIT_RESET;
            in_use_reg     <= '0;
            pend_total_reg <= '0;
            pend_k_reg     <= '0;
            eol_reg        <= 1'b0;
            ptr_reg        <= '0;
            fill_j_reg     <= '0;
            fill_i_reg     <= '0;
            rep_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            pend_total_reg <= pend_total_next;
            pend_k_reg     <= pend_k_next;
            eol_reg        <= eol_next;
            ptr_reg        <= ptr_next;
            fill_j_reg     <= fill_j_next;
            fill_i_reg     <= fill_i_next;
            rep_reg        <= rep_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= (state_reg == ST_REPORT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_write)
        begin
            pend_mem[pend_total_reg[PIDX_W-1:0]] <= holder_id;
        end
        if (out_load && (state_reg == ST_REPORT))
        begin
            if (in_use_reg == '0)
            begin
                slot_id_reg    <= '0;
                slot_count_reg <= '0;
                slot_valid_reg <= 1'b0;
                last_reg       <= 1'b1;
            end
            else
            begin
                slot_id_reg    <= cq[rep_idx].ident;
                slot_count_reg <= cq[rep_idx].hits;
                slot_valid_reg <= 1'b1;
                last_reg       <= ((rep_reg + CNT_W'(1)) == in_use_reg);
            end
            total_reg <= 4'(in_use_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign slot_id         = slot_id_reg;
    assign slot_count      = slot_count_reg;
    assign slot_valid      = slot_valid_reg;
    assign candidate_total = total_reg;
    assign last_of_run     = last_reg;

    a_in_use_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (in_use_reg >= $past(in_use_reg)))
        else $error("candidate count decreased");

    a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= CNT_W'(CAND_SLOTS))
        else $error("candidate count beyond table size");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_total_reg <= PCNT_W'(HOLDER_SLOTS))
        else $error("holder buffer overfilled");

    a_fill_needs_ids: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (pend_k_reg != '0))
        else $error("refill without buffered ids");

endmodule
